FILE: rtl/core/kwhm_pkg.sv
// ----------------------------------------------------------------------------
// kwhm_pkg
// Shared widths, constants and the heap entry type of the k-way heap merge.
// ----------------------------------------------------------------------------
package kwhm_pkg;

    // Field widths of the stream items
    localparam int KEY_BITS     = 32;
    localparam int SRC_BITS     = 3;
    localparam int WAYS_BITS    = 4;
    localparam int DEF_MAX_WAYS = 8;

    // Byte-aligned payload width: source and key
    localparam int TDATA_BITS = ((SRC_BITS + KEY_BITS + 7) / 8) * 8;

    // Number of ways after reset
    localparam logic [WAYS_BITS-1:0] WAYS_RESET = WAYS_BITS'(3);

    // Heap entry: the key's top bit is the end-of-stream sentinel
    typedef struct packed {
        logic [KEY_BITS:0]   key;
        logic [SRC_BITS-1:0] src;
    } heap_entry_t;

endpackage

FILE: rtl/core/kwhm_heap_mem.sv
// ----------------------------------------------------------------------------
// kwhm_heap_mem
// Heap storage: one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module kwhm_heap_mem
    import kwhm_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WAYS,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  heap_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr_a,
    input  logic [AW-1:0]     rd_addr_b,
    output heap_entry_t       rd_data_a,
    output heap_entry_t       rd_data_b
);

    heap_entry_t mem [DEPTH];

    // Write one entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read two entries, hold data when no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

FILE: rtl/core/kwhm_cmp.sv
// ----------------------------------------------------------------------------
// kwhm_cmp
// Shared key comparator: picks the candidate only if strictly smaller.
// ----------------------------------------------------------------------------
module kwhm_cmp
    import kwhm_pkg::*;
(
    input  heap_entry_t cur,
    input  heap_entry_t cand,
    output logic        take,
    output heap_entry_t pick
);

    // Ties keep the current pick
    assign take = (cand.key < cur.key);
    assign pick = take ? cand : cur;

endmodule

FILE: rtl/core/kway_heap_merge_top.sv
// ----------------------------------------------------------------------------
// kway_heap_merge_top
// K-way merge of sorted key streams through a binary min-heap.
//
//   channel   direction  handshake           payload
//   s_*       in         s_tvalid/s_tready   tdata: source, key; tuser: at_end
//   m_*       out        m_tvalid/m_tready   tdata: min_key, min_source;
//                                            tuser: done_res
//   cfg_*     in         cfg_wen             cfg_wdata: ways
//
// A fill item that does not complete the fill only writes its slot. A merge
// item runs, for each level where the hole has a child, a heap memory read,
// a left compare and a right compare on the one shared comparator, plus a
// final write into the hole when the hole ends at a leaf.
// The last fill item sifts nodes (ways-1)/2 down to 0, bottom-up, before its result.
// Reset is synchronous, active low; the heap memory is not cleared.
// The input stalls while an item is in work or its result waits for a free
// output register.
// ----------------------------------------------------------------------------
module kway_heap_merge_top
    import kwhm_pkg::*;
#(
    parameter int MAX_WAYS = DEF_MAX_WAYS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wen,
    input  logic [WAYS_BITS-1:0]  cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,   // source[2:0], key[34:3], zero pad
    input  logic                  s_tuser,   // at_end
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,   // min_key[31:0], min_source[34:32], pad
    output logic                  m_tuser    // done_res
);

    localparam int IW   = $clog2(MAX_WAYS);
    localparam int NW   = IW + 2;
    localparam int CMPW = (NW > WAYS_BITS) ? NW : WAYS_BITS;
    localparam int PADW = TDATA_BITS - KEY_BITS - SRC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_LOADW,
        S_RD,
        S_CMPL,
        S_CMPR,
        S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic                  merging_reg, merging_next;
    logic [WAYS_BITS-1:0]  fill_count_reg, fill_count_next;
    logic [WAYS_BITS-1:0]  ended_count_reg, ended_count_next;
    logic [WAYS_BITS-1:0]  ways_reg, ways_next;
    logic                  build_reg, build_next;
    logic [IW-1:0]         build_i_reg, build_i_next;
    logic [IW-1:0]         i_reg, i_next;
    logic [IW-1:0]         best_reg, best_next;
    heap_entry_t           v_reg, v_next;
    heap_entry_t           bent_reg, bent_next;
    heap_entry_t           root_reg, root_next;
    logic                  out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0]   out_key_reg, out_key_next;
    logic [SRC_BITS-1:0]   out_src_reg, out_src_next;
    logic                  out_done_reg, out_done_next;

    // memory and comparator hookup
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    heap_entry_t           wr_data;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr_a;
    logic [IW-1:0]         rd_addr_b;
    heap_entry_t           rd_data_a;
    heap_entry_t           rd_data_b;
    heap_entry_t           cmp_cur;
    heap_entry_t           cmp_cand;
    logic                  cmp_take;
    heap_entry_t           cmp_pick;

    // decode and helpers
    logic                  s_fire;
    logic                  in_end;
    logic [KEY_BITS:0]     in_key;
    logic [WAYS_BITS-1:0]  cfg_ways;
    logic [IW-1:0]         fill_slot;
    logic [WAYS_BITS-1:0]  fill_inc;
    logic [IW-1:0]         start_i;
    logic [CMPW-1:0]       left_idx;
    logic [CMPW-1:0]       right_idx;
    logic [CMPW-1:0]       ways_ext;
    logic                  left_ok;
    logic                  right_ok;
    logic                  all_ended;
    logic                  sift_end;

    kwhm_heap_mem #(
        .DEPTH (MAX_WAYS)
    ) u_mem (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    kwhm_cmp u_cmp (
        .cur  (cmp_cur),
        .cand (cmp_cand),
        .take (cmp_take),
        .pick (cmp_pick)
    );

    // Decode the input item; an ended stream carries the sentinel key
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid & s_tready;
    assign in_end   = s_tuser;
    assign in_key   = in_end ? {1'b1, KEY_BITS'(0)}
                             : {1'b0, s_tdata[SRC_BITS +: KEY_BITS]};

    // Clamp the written way count into its legal range
    always_comb begin
        if (cfg_wdata == '0) begin
            cfg_ways = WAYS_BITS'(1);
        end else if (int'(cfg_wdata) > MAX_WAYS) begin
            cfg_ways = WAYS_BITS'(MAX_WAYS);
        end else begin
            cfg_ways = cfg_wdata;
        end
    end

    assign fill_slot = (int'(fill_count_reg) >= MAX_WAYS) ? IW'(MAX_WAYS - 1)
                                                          : IW'(fill_count_reg);
    assign fill_inc  = fill_count_reg + 1'b1;
    assign start_i   = IW'((ways_reg - 1'b1) >> 1);
    assign all_ended = (ended_count_reg >= ways_reg);

    // Child indexes of the current hole
    assign left_idx  = (CMPW'(i_reg) << 1) + CMPW'(1);
    assign right_idx = left_idx + CMPW'(1);
    assign ways_ext  = CMPW'(ways_reg);
    assign left_ok   = (left_idx < ways_ext);
    assign right_ok  = (right_idx < ways_ext);

    // Steer the shared comparator: left child against the sifted entry,
    // then right child against the pick so far
    assign cmp_cur  = (state_reg == S_CMPL) ? v_reg : bent_reg;
    assign cmp_cand = (state_reg == S_CMPL) ? rd_data_a : rd_data_b;

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        merging_next     = merging_reg;
        fill_count_next  = fill_count_reg;
        ended_count_next = ended_count_reg;
        ways_next        = ways_reg;
        build_next       = build_reg;
        build_i_next     = build_i_reg;
        i_next           = i_reg;
        best_next        = best_reg;
        v_next           = v_reg;
        bent_next        = bent_reg;
        root_next        = root_reg;
        out_valid_next   = out_valid_reg;
        out_key_next     = out_key_reg;
        out_src_next     = out_src_reg;
        out_done_next    = out_done_reg;
        wr_en            = 1'b0;
        wr_addr          = i_reg;
        wr_data          = v_reg;
        rd_en            = 1'b0;
        rd_addr_a        = IW'(left_idx);
        rd_addr_b        = IW'(right_idx);
        sift_end         = 1'b0;

        // Retire the output item
        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (!merging_reg) begin
                        // Fill one slot; the slot number is the stream
                        wr_en            = 1'b1;
                        wr_addr          = fill_slot;
                        wr_data.key      = in_key;
                        wr_data.src      = SRC_BITS'(fill_slot);
                        fill_count_next  = fill_inc;
                        ended_count_next = ended_count_reg + WAYS_BITS'(in_end);
                        if (fill_inc >= ways_reg) begin
                            build_next   = 1'b1;
                            build_i_next = start_i;
                            i_next       = start_i;
                            state_next   = S_LOAD;
                        end
                    end else if (all_ended) begin
                        state_next = S_EMIT;
                    end else begin
                        // Replace the root with the next key of its stream
                        v_next.key       = in_key;
                        v_next.src       = root_reg.src;
                        ended_count_next = ended_count_reg + WAYS_BITS'(in_end);
                        build_next       = 1'b0;
                        i_next           = '0;
                        state_next       = S_RD;
                    end
                end
            end
            S_LOAD: begin
                // Fetch the entry that starts this sift
                rd_en      = 1'b1;
                rd_addr_a  = i_reg;
                state_next = S_LOADW;
            end
            S_LOADW: begin
                v_next     = rd_data_a;
                state_next = S_RD;
            end
            S_RD: begin
                if (left_ok) begin
                    rd_en      = 1'b1;
                    state_next = S_CMPL;
                end else begin
                    // Leaf reached: drop the entry into the hole
                    wr_en    = 1'b1;
                    sift_end = 1'b1;
                end
            end
            S_CMPL: begin
                best_next  = cmp_take ? IW'(left_idx) : i_reg;
                bent_next  = cmp_pick;
                state_next = S_CMPR;
            end
            S_CMPR: begin
                wr_en = 1'b1;
                if (right_ok && cmp_take) begin
                    wr_data    = rd_data_b;
                    i_next     = IW'(right_idx);
                    state_next = S_RD;
                end else if (best_reg != i_reg) begin
                    wr_data    = bent_reg;
                    i_next     = best_reg;
                    state_next = S_RD;
                end else begin
                    sift_end = 1'b1;
                end
            end
            S_EMIT: begin
                // Load the result once the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    if (all_ended) begin
                        out_key_next  = '0;
                        out_src_next  = '0;
                        out_done_next = 1'b1;
                    end else begin
                        out_key_next  = root_reg.key[KEY_BITS-1:0];
                        out_src_next  = root_reg.src;
                        out_done_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // End of one sift: next inner node while building, else emit
        if (sift_end) begin
            if (build_reg && (build_i_reg != '0)) begin
                build_i_next = build_i_reg - 1'b1;
                i_next       = build_i_reg - 1'b1;
                state_next   = S_LOAD;
            end else begin
                build_next   = 1'b0;
                merging_next = 1'b1;
                state_next   = S_EMIT;
            end
        end

        // Mirror the root entry
        if (wr_en && (wr_addr == '0)) begin
            root_next = wr_data;
        end

        // A new way count restarts the pass
        if (cfg_wen) begin
            ways_next        = cfg_ways;
            fill_count_next  = '0;
            ended_count_next = '0;
            merging_next     = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            merging_reg     <= 1'b0;
            fill_count_reg  <= '0;
            ended_count_reg <= '0;
            ways_reg        <= WAYS_RESET;
            build_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            merging_reg     <= merging_next;
            fill_count_reg  <= fill_count_next;
            ended_count_reg <= ended_count_next;
            ways_reg        <= ways_next;
            build_reg       <= build_next;
            out_valid_reg   <= out_valid_next;
        end
        build_i_reg  <= build_i_next;
        i_reg        <= i_next;
        best_reg     <= best_next;
        v_reg        <= v_next;
        bent_reg     <= bent_next;
        root_reg     <= root_next;
        out_key_reg  <= out_key_next;
        out_src_reg  <= out_src_next;
        out_done_reg <= out_done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {PADW'(0), out_src_reg, out_key_reg};
    assign m_tuser  = out_done_reg;

    // Ended streams never outnumber the ways of the pass
    a_ended_le_ways: assert property (@(posedge aclk) disable iff (!aresetn)
        ended_count_reg <= ways_reg)
        else $error("ended stream count exceeds way count");

    // A result is only produced once the heap is built
    a_emit_merging: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> merging_reg)
        else $error("result issued during fill phase");

    // The sift hole always lies inside the live heap
    a_hole_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD) |-> (CMPW'(i_reg) < ways_ext))
        else $error("sift index outside heap");

endmodule

FILE: verif/kwhm_merge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwhm_merge_checker
// Watches the config port and both streams of the k-way heap merge. It keeps
// its own min-heap, predicts the merged minimum for each accepted item that
// yields one, and compares each result item against the oldest prediction.
// ----------------------------------------------------------------------------
module kwhm_merge_checker
    import kwhm_pkg::*;
#(
    parameter int MAX_WAYS = DEF_MAX_WAYS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic [WAYS_BITS-1:0]  cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_BITS-1:0] m_tdata,
    input  logic                  m_tuser,
    output int                    pending_count,
    output int                    mismatch_count
);

    typedef struct packed {
        logic                done;
        logic [SRC_BITS-1:0] src;
        logic [KEY_BITS-1:0] key;
    } merge_result_t;

    // Shadow heap and pass state
    logic [KEY_BITS:0]   heap_key [MAX_WAYS];
    logic [SRC_BITS-1:0] heap_src [MAX_WAYS];
    int unsigned         fill_cnt;
    int unsigned         ended_cnt;
    int unsigned         ways_now;
    bit                  merging;

    merge_result_t minima_due[$];
    merge_result_t got_min;
    merge_result_t want_min;
    int            result_no;

    // Sift one entry down; ties keep the parent, right child needs strictly less
    function automatic void sift_from(int unsigned start);
        int unsigned         i;
        int unsigned         l;
        int unsigned         r;
        int unsigned         pick;
        logic [KEY_BITS:0]   tk;
        logic [SRC_BITS-1:0] ts;
        i = start;
        while (1) begin
            l    = 2 * i + 1;
            r    = 2 * i + 2;
            pick = i;
            if (l < ways_now && heap_key[l] < heap_key[i]) pick = l;
            if (r < ways_now && heap_key[r] < heap_key[pick]) pick = r;
            if (pick == i) break;
            tk             = heap_key[i];
            ts             = heap_src[i];
            heap_key[i]    = heap_key[pick];
            heap_src[i]    = heap_src[pick];
            heap_key[pick] = tk;
            heap_src[pick] = ts;
            i              = pick;
        end
    endfunction

    function automatic merge_result_t current_min();
        merge_result_t res;
        if (ended_cnt >= ways_now) begin
            res = '{done: 1'b1, src: '0, key: '0};
        end else begin
            res = '{done: 1'b0, src: heap_src[0], key: heap_key[0][KEY_BITS-1:0]};
        end
        return res;
    endfunction

    // Apply one input item; queue the minimum it produces, if any
    function automatic void take_item(logic [KEY_BITS-1:0] key, logic at_end);
        logic [KEY_BITS:0] k;
        int unsigned       slot;
        k = at_end ? {1'b1, {KEY_BITS{1'b0}}} : {1'b0, key};
        if (!merging) begin
            slot           = (fill_cnt >= MAX_WAYS) ? MAX_WAYS - 1 : fill_cnt;
            heap_key[slot] = k;
            heap_src[slot] = SRC_BITS'(slot);
            if (at_end) ended_cnt++;
            fill_cnt++;
            if (fill_cnt >= ways_now) begin
                for (int i = (int'(ways_now) - 1) / 2; i >= 0; i--) sift_from(i);
                merging = 1'b1;
                minima_due.push_back(current_min());
            end
        end else if (ended_cnt >= ways_now) begin
            minima_due.push_back(current_min());
        end else begin
            heap_key[0] = k;
            if (at_end) ended_cnt++;
            sift_from(0);
            minima_due.push_back(current_min());
        end
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("result %0d %s: min_key exp %h got %h, min_source exp %0d got %0d,",
                     result_no, what, want_min.key, got_min.key,
                     want_min.src, got_min.src);
            $display("    done exp %0b got %0b", want_min.done, got_min.done);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ways_now  = WAYS_RESET;
            fill_cnt  = 0;
            ended_cnt = 0;
            merging   = 1'b0;
            minima_due.delete();
        end else begin
            // Config write restarts the pass
            if (cfg_wen) begin
                ways_now  = (cfg_wdata == 0) ? 1 :
                            (cfg_wdata > MAX_WAYS) ? MAX_WAYS : cfg_wdata;
                fill_cnt  = 0;
                ended_cnt = 0;
                merging   = 1'b0;
            end
            // Check the result item against the oldest prediction
            if (m_tvalid && m_tready) begin
                got_min.key  = m_tdata[KEY_BITS-1:0];
                got_min.src  = m_tdata[KEY_BITS +: SRC_BITS];
                got_min.done = m_tuser;
                if (minima_due.size() == 0) begin
                    want_min = '0;
                    note_mismatch("unexpected");
                end else begin
                    want_min = minima_due.pop_front();
                    if (got_min.key !== want_min.key || got_min.src !== want_min.src ||
                        got_min.done !== want_min.done) begin
                        note_mismatch("wrong");
                    end
                end
                result_no++;
            end
            // Predict from the accepted input item
            if (s_tvalid && s_tready) begin
                take_item(s_tdata[SRC_BITS +: KEY_BITS], s_tuser);
            end
        end
        pending_count <= minima_due.size();
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the k-way heap merge: sorted key lanes merged pass by pass
// over a range of way counts, plus truncated passes, stray items, random
// stalls on both sides and one long output hold-off. Checking is done by
// kwhm_merge_checker.
// ----------------------------------------------------------------------------
module tb;
    import kwhm_pkg::*;

    localparam int          ITEM_TARGET = 1800;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          SETTLE      = 40;
    localparam int          HOLD_CYCLES = 400;
    localparam int          NO_CUT      = 1 << 30;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [WAYS_BITS-1:0]  cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata   = '0;   // source[2:0], key[34:3], zero pad
    logic                  s_tuser   = 1'b0; // at_end
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;          // min_key[31:0], min_source[34:32], pad
    logic                  m_tuser;          // done_res

    int pending_count;
    int mismatch_count;

    // Stimulus control
    logic [KEY_BITS-1:0] lane_keys [DEF_MAX_WAYS][$];
    int                  items_sent    = 0;
    int                  src_idle_pct  = 26;
    int                  sink_idle_pct = 26;
    logic                hold_req      = 1'b0;
    logic                hold_done     = 1'b0;
    int                  hold_left     = 0;
    int unsigned         cycle_count   = 0;

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    kway_heap_merge_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    kwhm_merge_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .pending_count  (pending_count),
        .mismatch_count (mismatch_count)
    );

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
        end
    end

    function automatic int lanes_for(input logic [WAYS_BITS-1:0] v);
        return (v == 0) ? 1 : (v > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(v);
    endfunction

    // Offer one item, wait for acceptance, then maybe drop valid and idle
    task automatic send_item(input logic [SRC_BITS-1:0] src, input logic [KEY_BITS-1:0] key,
                             input logic at_end);
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_BITS'({key, src});
        s_tuser  <= at_end;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if ($urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every predicted result has drained
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_ways(input logic [WAYS_BITS-1:0] v);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    // Build ascending key lanes for the first n lanes, clear the rest
    task automatic fill_lanes(input int n, input int max_len, input int mode);
        logic [KEY_BITS-1:0] k;
        logic [KEY_BITS:0]   sum;
        int                  len;
        for (int s = 0; s < DEF_MAX_WAYS; s++) begin
            lane_keys[s].delete();
            if (s < n) begin
                len = $urandom_range(max_len, 0);
                case (mode)
                    0: k = $urandom;
                    1: k = $urandom_range(15, 0);
                    2: k = 32'hFFFF_FFFF - $urandom_range(20, 0);
                    default: k = '0;
                endcase
                for (int j = 0; j < len; j++) begin
                    lane_keys[s].push_back(k);
                    sum = {1'b0, k} + ((mode == 0) ? $urandom_range(32'h0FFF_FFFF, 0)
                                                   : $urandom_range(3, 0));
                    k   = sum[KEY_BITS] ? '1 : sum[KEY_BITS-1:0];
                end
            end
        end
    endtask

    // Send the next key of a lane, or its end marker once the lane is empty
    task automatic feed_lane(input int s, output logic [KEY_BITS:0] head_key);
        logic [SRC_BITS-1:0] src;
        logic [KEY_BITS-1:0] k;
        src = ($urandom_range(99, 0) < 85) ? SRC_BITS'(s) : SRC_BITS'($urandom_range(7, 0));
        if (lane_keys[s].size() == 0) begin
            send_item(src, $urandom, 1'b1);
            head_key = {1'b1, {KEY_BITS{1'b0}}};
        end else begin
            k = lane_keys[s].pop_front();
            send_item(src, k, 1'b0);
            head_key = {1'b0, k};
        end
    endtask

    // Merge the lanes: fill each lane once, then always feed the lane at the minimum
    task automatic drive_pass(input int n, input int cut, input int extra);
        logic [KEY_BITS:0] head [DEF_MAX_WAYS];
        int                fed;
        int                pick;
        fed = 0;
        for (int s = 0; s < n; s++) begin
            if (fed >= cut) return;
            feed_lane(s, head[s]);
            fed++;
        end
        while (1) begin
            pick = -1;
            for (int s = 0; s < n; s++) begin
                if (!head[s][KEY_BITS] && (pick < 0 || head[s] < head[pick])) pick = s;
            end
            if (pick < 0) break;
            if (fed >= cut) return;
            if ($urandom_range(99, 0) < 2) quiesce();
            feed_lane(pick, head[pick]);
            fed++;
        end
        // Items past the end of the pass
        repeat (extra) begin
            send_item(SRC_BITS'($urandom_range(7, 0)), $urandom,
                      1'($urandom_range(1, 0)));
        end
    endtask

    initial begin
        int                   n;
        int                   kind;
        int                   pass_no;
        logic [WAYS_BITS-1:0] wv;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset way count: extreme keys, one lane empty at fill, item after done
        fill_lanes(0, 0, 0);
        lane_keys[0].push_back(32'h0000_0000);
        lane_keys[1].push_back(32'hFFFF_FFFF);
        drive_pass(3, NO_CUT, 1);
        quiesce();

        // Abandon a pass partway through the fill
        write_ways(WAYS_BITS'(4));
        fill_lanes(4, 2, 0);
        drive_pass(4, 2, 0);
        quiesce();

        // Zero ways maps to one lane
        write_ways(WAYS_BITS'(0));
        fill_lanes(0, 0, 0);
        lane_keys[0].push_back(32'd5);
        drive_pass(1, NO_CUT, 0);
        quiesce();

        // Over-range ways maps to the maximum; all keys equal to exercise ties
        write_ways(WAYS_BITS'(15));
        fill_lanes(0, 0, 0);
        for (int s = 0; s < DEF_MAX_WAYS; s++) lane_keys[s].push_back(32'd7);
        drive_pass(DEF_MAX_WAYS, 12, 0);
        quiesce();

        // Every lane empty: done straight out of the fill
        write_ways(WAYS_BITS'(2));
        fill_lanes(0, 0, 0);
        drive_pass(2, NO_CUT, 1);
        quiesce();

        // Random passes
        pass_no = 0;
        while (items_sent < ITEM_TARGET) begin
            src_idle_pct  = (pass_no >= 12 && pass_no < 30) ? 0 : 26;
            sink_idle_pct = src_idle_pct;
            if ($urandom_range(99, 0) < 6) begin
                wv = ($urandom_range(1, 0) != 0) ? WAYS_BITS'($urandom_range(15, 9)) : '0;
            end else begin
                wv = WAYS_BITS'($urandom_range(8, 1));
            end
            if (pass_no == 6) wv = WAYS_BITS'(DEF_MAX_WAYS);
            write_ways(wv);
            n = lanes_for(wv);
            if (pass_no == 6) begin
                // Hold the output while the lanes keep coming
                fill_lanes(n, 6, 0);
                hold_req = 1'b1;
                drive_pass(n, NO_CUT, 0);
            end else begin
                fill_lanes(n, ($urandom_range(99, 0) < 20) ? 8 : 3, $urandom_range(3, 0));
                kind = $urandom_range(99, 0);
                if (kind < 10) begin
                    repeat ($urandom_range(12, 1)) begin
                        send_item(SRC_BITS'($urandom_range(7, 0)), $urandom,
                                  1'($urandom_range(3, 0) == 0));
                    end
                end else if (kind < 20) begin
                    drive_pass(n, $urandom_range(n + 3, 1), 0);
                end else begin
                    drive_pass(n, NO_CUT, $urandom_range(2, 0));
                end
            end
            quiesce();
            pass_no++;
        end

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
